// ===== hdl/lssc_pkg.sv =====
package lssc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_BITS   = 15;
    localparam int SLOPE_BITS = 32;
    // y*2^F - n and friends
    localparam int NUM_BITS   = COORD_BITS + FRAC_BITS + 2;
    localparam int MAG_BITS   = NUM_BITS - 1;
    // m*x + n, one bit of headroom over the product
    localparam int PROD_BITS  = SLOPE_BITS + COORD_BITS + 1;
    // one quotient bit per divider stage
    localparam int DIV_STEPS  = COORD_BITS;
    localparam int DIV_LAT    = DIV_STEPS + 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [PROD_BITS-1:0] POS_LIM = PROD_BITS'(2**(COORD_BITS-1) - 1);
    localparam logic [PROD_BITS-1:0] NEG_LIM = PROD_BITS'(2**(COORD_BITS-1));

    typedef enum logic [1:0] {
        REQ_BOTH   = 2'd0,
        REQ_X_ONLY = 2'd1,
        REQ_Y_ONLY = 2'd2
    } req_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic neg;
        logic num_neg;
        logic num_zero;
        logic den_zero;
        logic ovf;
        logic rnd;
    } div_ctl_t;

    typedef struct packed {
        coord_t xa;
        coord_t xb;
        coord_t ya;
        coord_t yb;
        coord_t y_left;
        coord_t y_right;
        coord_t x_top;
        coord_t x_bot;
    } clip_in_t;

    typedef struct packed {
        logic   rejected;
        coord_t xa;
        coord_t xb;
        coord_t ya;
        coord_t yb;
    } clip_out_t;

    // sign and magnitude to a saturated coordinate
    function automatic coord_t sat_mag(input logic neg, input logic [PROD_BITS-1:0] mag);
        logic [PROD_BITS-1:0] neg_mag;
        coord_t res;
        neg_mag = -mag;
        if (neg) begin
            if (mag > NEG_LIM) res = C_MIN;
            else res = neg_mag[COORD_BITS-1:0];
        end else begin
            if (mag > POS_LIM) res = C_MAX;
            else res = mag[COORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/lssc_div.sv =====
module lssc_div
    import lssc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         en,
    input  logic                         rnd,
    input  logic signed [NUM_BITS-1:0]   num,
    input  logic signed [SLOPE_BITS-1:0] den,
    output coord_t                       quo
);

    localparam int SH_BITS = SLOPE_BITS + DIV_STEPS;

    logic [MAG_BITS-1:0]   an_reg;
    logic [SLOPE_BITS-1:0] ad_reg;
    div_ctl_t              ctl_reg;
    div_ctl_t              ctl0_next;

    logic [MAG_BITS-1:0]   rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]  quo_reg [0:DIV_STEPS];
    logic [SLOPE_BITS-1:0] den_reg [0:DIV_STEPS];
    div_ctl_t              cs_reg  [0:DIV_STEPS];

    coord_t                quo_reg_out;
    coord_t                quo_next;

    // absolute values and signs
    always_ff @(posedge aclk) begin
        if (en) begin
            an_reg           <= num[NUM_BITS-1] ? MAG_BITS'(-num) : MAG_BITS'(num);
            ad_reg           <= den[SLOPE_BITS-1] ? SLOPE_BITS'(-den) : SLOPE_BITS'(den);
            ctl_reg.neg      <= num[NUM_BITS-1] ^ den[SLOPE_BITS-1];
            ctl_reg.num_neg  <= num[NUM_BITS-1];
            ctl_reg.num_zero <= (num == '0);
            ctl_reg.den_zero <= (den == '0);
            ctl_reg.ovf      <= 1'b0;
            ctl_reg.rnd      <= rnd;
        end
    end

    // quotient too large for the coordinate range
    always_comb begin
        ctl0_next     = ctl_reg;
        ctl0_next.ovf = {{(SH_BITS-MAG_BITS){1'b0}}, an_reg} >=
                        {ad_reg, {DIV_STEPS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= an_reg;
            quo_reg[0] <= '0;
            den_reg[0] <= ad_reg;
            cs_reg[0]  <= ctl0_next;
        end
    end

    // restoring steps, MSB first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        logic [SH_BITS-1:0] trial;
        logic [SH_BITS-1:0] rem_ext;
        logic               take;

        assign trial   = {{DIV_STEPS{1'b0}}, den_reg[k]} << BIT;
        assign rem_ext = SH_BITS'(rem_reg[k]);
        assign take    = rem_ext >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? MAG_BITS'(rem_ext - trial) : rem_reg[k];
                quo_reg[k+1] <= {quo_reg[k][DIV_STEPS-2:0], take};
                den_reg[k+1] <= den_reg[k];
                cs_reg[k+1]  <= cs_reg[k];
            end
        end
    end

    // rounding, sign and saturation
    always_comb begin
        logic [MAG_BITS:0]    rem2;
        logic                 up;
        logic [PROD_BITS-1:0] mag;
        div_ctl_t             c;
        c    = cs_reg[DIV_STEPS];
        rem2 = {rem_reg[DIV_STEPS], 1'b0};
        up   = c.rnd && (rem2 >= (MAG_BITS+1)'(den_reg[DIV_STEPS]));
        mag  = PROD_BITS'(quo_reg[DIV_STEPS]) + PROD_BITS'(up);
        if (c.den_zero) begin
            if (c.num_zero) quo_next = '0;
            else quo_next = c.num_neg ? C_MIN : C_MAX;
        end else if (c.ovf) begin
            quo_next = c.neg ? C_MIN : C_MAX;
        end else begin
            quo_next = sat_mag(c.neg, mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg_out <= quo_next;
        end
    end

    assign quo = quo_reg_out;

endmodule

// ===== hdl/lssc_clip.sv =====
module lssc_clip
    import lssc_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  coord_t    wr,
    input  coord_t    ht,
    input  clip_in_t  cin,
    output clip_out_t cout
);

    coord_t xa1_reg, xb1_reg, ya1_reg, yb1_reg, y_right1_reg, x_bot1_reg;
    logic   rej1_reg;
    coord_t xa1_next, xb1_next, ya1_next, yb1_next;
    logic   rej1_next;
    clip_out_t out_reg, out_next;

    // left, then top
    always_comb begin
        xa1_next  = cin.xa;
        xb1_next  = cin.xb;
        ya1_next  = cin.ya;
        yb1_next  = cin.yb;
        rej1_next = 1'b0;
        if (xa1_next < coord_t'(0) && xb1_next < coord_t'(0)) begin
            rej1_next = 1'b1;
        end else if (xa1_next < coord_t'(0)) begin
            xa1_next = '0;
            ya1_next = cin.y_left;
        end else if (xb1_next < coord_t'(0)) begin
            xb1_next = '0;
            yb1_next = cin.y_left;
        end
        if (!rej1_next) begin
            if (ya1_next > ht && yb1_next > ht) begin
                rej1_next = 1'b1;
            end else if (ya1_next > ht) begin
                ya1_next = ht;
                xa1_next = cin.x_top;
            end else if (yb1_next > ht) begin
                yb1_next = ht;
                xb1_next = cin.x_top;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa1_reg      <= xa1_next;
            xb1_reg      <= xb1_next;
            ya1_reg      <= ya1_next;
            yb1_reg      <= yb1_next;
            rej1_reg     <= rej1_next;
            y_right1_reg <= cin.y_right;
            x_bot1_reg   <= cin.x_bot;
        end
    end

    // right, then bottom
    always_comb begin
        out_next.xa       = xa1_reg;
        out_next.xb       = xb1_reg;
        out_next.ya       = ya1_reg;
        out_next.yb       = yb1_reg;
        out_next.rejected = rej1_reg;
        if (!out_next.rejected) begin
            if (out_next.xa > wr && out_next.xb > wr) begin
                out_next.rejected = 1'b1;
            end else if (out_next.xa > wr) begin
                out_next.xa = wr;
                out_next.ya = y_right1_reg;
            end else if (out_next.xb > wr) begin
                out_next.xb = wr;
                out_next.yb = y_right1_reg;
            end
        end
        if (!out_next.rejected) begin
            if (out_next.ya < coord_t'(0) && out_next.yb < coord_t'(0)) begin
                out_next.rejected = 1'b1;
            end else if (out_next.ya < coord_t'(0)) begin
                out_next.ya = '0;
                out_next.xa = x_bot1_reg;
            end else if (out_next.yb < coord_t'(0)) begin
                out_next.yb = '0;
                out_next.xb = x_bot1_reg;
            end
        end
        if (out_next.rejected) begin
            out_next.xa = '0;
            out_next.xb = '0;
            out_next.ya = '0;
            out_next.yb = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign cout = out_reg;

endmodule

// ===== hdl/line_segment_screen_clipper_unit.sv =====
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       s_tdata: segment, line; s_tuser: req_type
// m_        out  m_tvalid / m_tready       m_tdata: clipped endpoints; m_tuser: rejected
// APB       in   psel / penable / pready   screen_width @0x0, screen_height @0x4
//
// One segment per cycle while the pipe is not held; the pipeline depth from accept to m_tvalid is
// set by the 16-step pipelined divider (one quotient bit per stage).
// aresetn is synchronous, active low; it clears the valid bits and sets the screen
// to 80 x 24. Payload registers are not reset.
// The whole pipe advances together; it holds while m_tvalid is high and m_tready low.
module line_segment_screen_clipper_unit
    import lssc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_start[15:0], x_end[31:16], y_start[47:32], y_end[63:48],
    // slope[95:64], intercept[127:96]
    input  logic [127:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // x_start_out[15:0], x_end_out[31:16], y_start_out[47:32], y_end_out[63:48]
    output logic [63:0]  m_tdata,
    // rejected[0]
    output logic [0:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Stage map: 1 input regs, 2 products and numerators, 3 sums, 4 rounding,
    // dividers land at DIV_STAGE, two clip stages follow.
    localparam int DIV_STAGE = DIV_LAT + 2;
    localparam int OUT_STAGE = DIV_STAGE + 2;
    localparam int SIDE_DLY  = DIV_STAGE - 4;

    typedef struct packed {
        logic [1:0] kind;
        coord_t     xa;
        coord_t     xb;
        coord_t     ya;
        coord_t     yb;
    } seg_t;

    typedef struct packed {
        seg_t   seg;
        coord_t ya_rnd;
        coord_t yb_rnd;
        coord_t y_left;
        coord_t y_right;
    } side_t;

    // Qn.F to integer: round half away from zero, or truncate toward zero
    function automatic coord_t q_conv(input logic signed [PROD_BITS-1:0] v, input logic rnd);
        logic                 neg;
        logic [PROD_BITS-1:0] mag;
        logic [PROD_BITS-1:0] sh;
        neg = v[PROD_BITS-1];
        mag = neg ? PROD_BITS'(-v) : PROD_BITS'(v);
        if (rnd) mag = mag + (PROD_BITS'(1) << (FRAC_BITS - 1));
        sh  = mag >> FRAC_BITS;
        return sat_mag(neg, sh);
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_BITS-1:0] w_reg, h_reg;
    logic                cfg_wr;
    coord_t              wr, ht;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= CFG_BITS'(80);
            h_reg <= CFG_BITS'(24);
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_WIDTH:  w_reg <= pwdata[CFG_BITS-1:0];
                REG_HEIGHT: h_reg <= pwdata[CFG_BITS-1:0];
                default:    w_reg <= w_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_WIDTH:  prdata = 32'(w_reg);
            REG_HEIGHT: prdata = 32'(h_reg);
            default:    prdata = '0;
        endcase
    end

    // right and top edges; a zero size puts the edge at -1
    assign wr = coord_t'({1'b0, w_reg}) - coord_t'(1);
    assign ht = coord_t'({1'b0, h_reg}) - coord_t'(1);

    // ---------------- flow control ----------------
    logic                 pipe_en;
    logic [OUT_STAGE:1]   v_reg;

    assign pipe_en  = !v_reg[OUT_STAGE] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = v_reg[OUT_STAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= {v_reg[OUT_STAGE-1:1], s_tvalid};
        end
    end

    // ---------------- stage 1: input registers ----------------
    seg_t                          seg1_reg;
    logic signed [SLOPE_BITS-1:0]  m1_reg, n1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            seg1_reg.kind <= s_tuser;
            seg1_reg.xa   <= s_tdata[15:0];
            seg1_reg.xb   <= s_tdata[31:16];
            seg1_reg.ya   <= s_tdata[47:32];
            seg1_reg.yb   <= s_tdata[63:48];
            m1_reg        <= s_tdata[95:64];
            n1_reg        <= s_tdata[127:96];
        end
    end

    // ---------------- stage 2: products, divider numerators ----------------
    seg_t                          seg2_reg;
    logic signed [SLOPE_BITS-1:0]  m2_reg, n2_reg;
    logic signed [PROD_BITS-2:0]   pa_reg, pb_reg, pr_reg;
    logic signed [NUM_BITS-1:0]    num_a_reg, num_b_reg, num_t_reg, num_bot_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            seg2_reg    <= seg1_reg;
            m2_reg      <= m1_reg;
            n2_reg      <= n1_reg;
            pa_reg      <= m1_reg * seg1_reg.xa;
            pb_reg      <= m1_reg * seg1_reg.xb;
            pr_reg      <= m1_reg * wr;
            num_a_reg   <= (NUM_BITS'(seg1_reg.ya) <<< FRAC_BITS) - NUM_BITS'(n1_reg);
            num_b_reg   <= (NUM_BITS'(seg1_reg.yb) <<< FRAC_BITS) - NUM_BITS'(n1_reg);
            num_t_reg   <= (NUM_BITS'(ht) <<< FRAC_BITS) - NUM_BITS'(n1_reg);
            num_bot_reg <= -NUM_BITS'(n1_reg);
        end
    end

    // x from y (rounded), top and bottom edge crossings (truncated)
    coord_t x_a_div, x_b_div, x_top_div, x_bot_div;

    lssc_div u_div_a (
        .aclk(aclk), .en(pipe_en), .rnd(1'b1),
        .num(num_a_reg), .den(m2_reg), .quo(x_a_div)
    );
    lssc_div u_div_b (
        .aclk(aclk), .en(pipe_en), .rnd(1'b1),
        .num(num_b_reg), .den(m2_reg), .quo(x_b_div)
    );
    lssc_div u_div_top (
        .aclk(aclk), .en(pipe_en), .rnd(1'b0),
        .num(num_t_reg), .den(m2_reg), .quo(x_top_div)
    );
    lssc_div u_div_bot (
        .aclk(aclk), .en(pipe_en), .rnd(1'b0),
        .num(num_bot_reg), .den(m2_reg), .quo(x_bot_div)
    );

    // ---------------- stage 3: m*x + n ----------------
    seg_t                          seg3_reg;
    logic signed [SLOPE_BITS-1:0]  n3_reg;
    logic signed [PROD_BITS-1:0]   sa_reg, sb_reg, sr_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            seg3_reg <= seg2_reg;
            n3_reg   <= n2_reg;
            sa_reg   <= PROD_BITS'(pa_reg) + PROD_BITS'(n2_reg);
            sb_reg   <= PROD_BITS'(pb_reg) + PROD_BITS'(n2_reg);
            sr_reg   <= PROD_BITS'(pr_reg) + PROD_BITS'(n2_reg);
        end
    end

    // ---------------- stage 4: to integers, then delay to the dividers ----------------
    side_t side_reg [0:SIDE_DLY];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0].seg     <= seg3_reg;
            side_reg[0].ya_rnd  <= q_conv(sa_reg, 1'b1);
            side_reg[0].yb_rnd  <= q_conv(sb_reg, 1'b1);
            side_reg[0].y_right <= q_conv(sr_reg, 1'b0);
            side_reg[0].y_left  <= q_conv(PROD_BITS'(n3_reg), 1'b0);
            for (int i = 1; i <= SIDE_DLY; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- request type picks the endpoints ----------------
    clip_in_t  cin;
    clip_out_t cout;
    side_t     sd;

    assign sd = side_reg[SIDE_DLY];

    always_comb begin
        cin.xa      = sd.seg.xa;
        cin.xb      = sd.seg.xb;
        cin.ya      = sd.seg.ya;
        cin.yb      = sd.seg.yb;
        cin.y_left  = sd.y_left;
        cin.y_right = sd.y_right;
        cin.x_top   = x_top_div;
        cin.x_bot   = x_bot_div;
        unique case (sd.seg.kind)
            REQ_X_ONLY: begin
                cin.ya = sd.ya_rnd;
                cin.yb = sd.yb_rnd;
            end
            REQ_Y_ONLY: begin
                cin.xa = x_a_div;
                cin.xb = x_b_div;
            end
            default: begin
                cin.xa = sd.seg.xa;
            end
        endcase
    end

    lssc_clip u_clip (
        .aclk(aclk),
        .en(pipe_en),
        .wr(wr),
        .ht(ht),
        .cin(cin),
        .cout(cout)
    );

    assign m_tdata = {cout.yb, cout.ya, cout.xb, cout.xa};
    assign m_tuser = cout.rejected;

    // ---------------- checks ----------------
    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cout.rejected |-> m_tdata == '0)
        else $error("rejected item carries nonzero coordinates");

    a_y_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !cout.rejected |-> !cout.ya[COORD_BITS-1] && !cout.yb[COORD_BITS-1])
        else $error("kept segment has an endpoint below the bottom edge");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(v_reg))
        else $error("valid bits moved during a stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[1])
        else $error("accepted item missing from the first stage");

endmodule
